[rtl/core/wht_pkg.sv]
package wht_pkg;

  localparam int unsigned IdxW   = 6;
  localparam int unsigned AmpW   = 16;
  localparam int unsigned QcntW  = 3;
  localparam int unsigned ProdW  = 33;
  localparam int unsigned FracW  = 15;

  localparam logic [QcntW-1:0]       QcntReset = 3'd6;
  localparam logic signed [AmpW-1:0] InvSqrt2  = 16'sd23170;
  localparam logic signed [ProdW-1:0] RoundHalf = 33'sd16384;
  localparam logic signed [ProdW-FracW-1:0] SatMax = 18'sd32767;
  localparam logic signed [ProdW-FracW-1:0] SatMin = -18'sd32768;

  typedef struct packed {
    logic [IdxW-1:0]        basis_index;
    logic signed [AmpW-1:0] amp_real;
    logic signed [AmpW-1:0] amp_imag;
    logic                   group_end;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]        out_index;
    logic signed [AmpW-1:0] out_real;
    logic signed [AmpW-1:0] out_imag;
    logic                   out_last;
  } out_item_t;

  typedef struct packed {
    logic signed [AmpW-1:0] re;
    logic signed [AmpW-1:0] im;
  } cplx_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BF_READ,
    ST_BF_MUL,
    ST_BF_WR_LO,
    ST_BF_WR_HI,
    ST_EM_READ,
    ST_EM_LOAD,
    ST_EM_WAIT
  } ctrl_state_e;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IdxW-1:0]  addr_a;
    logic [IdxW-1:0]  addr_b;
    logic             mul_en;
    logic             wr_lo;
    logic             wr_hi;
    logic [IdxW-1:0]  wr_addr;
    logic             out_load;
    logic             out_last;
    logic             clear;
    logic [QcntW-1:0] qubits;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_taken;
  } dp_status_t;

  // (p + 0.5 LSB) >>> 15, then clamp to the 16-bit range
  function automatic logic signed [AmpW-1:0] scale_round(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0]       p_r;
    logic signed [ProdW-FracW-1:0] sh;
    p_r = p + RoundHalf;
    sh  = p_r[ProdW-1:FracW];
    if (sh > SatMax) begin
      return SatMax[AmpW-1:0];
    end else if (sh < SatMin) begin
      return SatMin[AmpW-1:0];
    end
    return sh[AmpW-1:0];
  endfunction

endpackage

[rtl/core/wht_ctrl.sv]
module wht_ctrl #(
  parameter int unsigned AW = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    group_end_i,
  output logic                    in_ready_o,
  input  logic                    cfg_we_i,
  input  logic [wht_pkg::QcntW-1:0] cfg_wdata_i,
  output wht_pkg::ctrl_cmd_t      cmd_o,
  input  wht_pkg::dp_status_t     sts_i
);
  import wht_pkg::*;

  localparam logic [QcntW-1:0] MaxQ = QcntW'(AW);

  ctrl_state_e      state_q, state_d;
  logic [QcntW-1:0] cfg_q;
  logic [QcntW-1:0] qeff_q;
  logic [QcntW-1:0] stage_q;
  logic [AW-1:0]    j_q;
  logic [AW-1:0]    emit_q;

  logic [QcntW-1:0] q_now;
  logic [AW-1:0]    low_mask, lo, hi, last_j, last_emit;
  logic [IdxW-1:0]  lo_ext, hi_ext, emit_ext;
  logic             accept, j_done, stage_done, emit_done;

  always_comb begin
    if (cfg_q == '0) begin
      q_now = QcntW'(1);
    end else if (cfg_q > MaxQ) begin
      q_now = MaxQ;
    end else begin
      q_now = cfg_q;
    end
  end

  // butterfly pair: insert a zero at bit 'stage' of j
  always_comb begin
    low_mask  = ~({AW{1'b1}} << stage_q);
    lo        = ((j_q & ~low_mask) << 1) | (j_q & low_mask);
    hi        = lo | (AW'(1) << stage_q);
    last_j    = ~({AW{1'b1}} << (qeff_q - QcntW'(1)));
    last_emit = ~({AW{1'b1}} << qeff_q);
    lo_ext    = '0;
    hi_ext    = '0;
    emit_ext  = '0;
    lo_ext[AW-1:0]   = lo;
    hi_ext[AW-1:0]   = hi;
    emit_ext[AW-1:0] = emit_q;
  end

  assign accept     = in_valid_i && (state_q == ST_LOAD);
  assign j_done     = (j_q == last_j);
  assign stage_done = (stage_q == qeff_q - QcntW'(1));
  assign emit_done  = (emit_q == last_emit);
  assign in_ready_o = (state_q == ST_LOAD);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:     if (accept && group_end_i) state_d = ST_BF_READ;
      ST_BF_READ:  state_d = ST_BF_MUL;
      ST_BF_MUL:   state_d = ST_BF_WR_LO;
      ST_BF_WR_LO: state_d = ST_BF_WR_HI;
      ST_BF_WR_HI: begin
        if (j_done && stage_done) begin
          state_d = ST_EM_READ;
        end else begin
          state_d = ST_BF_READ;
        end
      end
      ST_EM_READ:  state_d = ST_EM_LOAD;
      ST_EM_LOAD:  state_d = ST_EM_WAIT;
      ST_EM_WAIT: begin
        if (sts_i.out_taken) begin
          state_d = emit_done ? ST_LOAD : ST_EM_READ;
        end
      end
      default:     state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.qubits   = (state_q == ST_LOAD) ? q_now : qeff_q;
    case (state_q)
      ST_LOAD:     cmd_o.load = accept;
      ST_BF_READ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.addr_a = lo_ext;
        cmd_o.addr_b = hi_ext;
      end
      ST_BF_MUL:   cmd_o.mul_en = 1'b1;
      ST_BF_WR_LO: begin
        cmd_o.wr_lo   = 1'b1;
        cmd_o.wr_addr = lo_ext;
      end
      ST_BF_WR_HI: begin
        cmd_o.wr_hi   = 1'b1;
        cmd_o.wr_addr = hi_ext;
      end
      ST_EM_READ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.addr_a = emit_ext;
        cmd_o.addr_b = emit_ext;
      end
      ST_EM_LOAD: begin
        cmd_o.out_load = 1'b1;
        cmd_o.addr_a   = emit_ext;
        cmd_o.out_last = emit_done;
      end
      ST_EM_WAIT:  cmd_o.clear = sts_i.out_taken && emit_done;
      default:     cmd_o.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cfg_q   <= QcntReset;
      qeff_q  <= QcntReset;
      stage_q <= '0;
      j_q     <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (accept && group_end_i) begin
        qeff_q  <= q_now;
        stage_q <= '0;
        j_q     <= '0;
      end
      if (state_q == ST_BF_WR_HI) begin
        if (j_done) begin
          j_q     <= '0;
          stage_q <= stage_q + QcntW'(1);
        end else begin
          j_q <= j_q + AW'(1);
        end
        emit_q <= '0;
      end
      if (state_q == ST_EM_WAIT && sts_i.out_taken) begin
        emit_q <= emit_q + AW'(1);
      end
    end
  end

endmodule

[rtl/core/wht_datapath.sv]
module wht_datapath #(
  parameter int unsigned AW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wht_pkg::in_item_t    in_item_i,
  input  wht_pkg::ctrl_cmd_t   cmd_i,
  output wht_pkg::dp_status_t  sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wht_pkg::out_item_t   out_item_o
);
  import wht_pkg::*;

  localparam int unsigned Depth = 1 << AW;

  cplx_t                   mem_q [Depth];
  logic [Depth-1:0]        valid_q;
  cplx_t                   rd_a_q, rd_b_q;
  logic                    rd_a_vld_q, rd_b_vld_q;
  cplx_t                   a, b;
  logic signed [ProdW-1:0] p_sre_q, p_sim_q, p_dre_q, p_dim_q;
  logic signed [AmpW:0]    s_re, s_im, d_re, d_im;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic                    in_range;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  cplx_t                   wr_data;

  assign in_range = ((in_item_i.basis_index >> cmd_i.qubits) == '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmd_i.wr_addr[AW-1:0];
    wr_data = '0;
    if (cmd_i.load) begin
      wr_en      = in_range;
      wr_addr    = in_item_i.basis_index[AW-1:0];
      wr_data.re = in_item_i.amp_real;
      wr_data.im = in_item_i.amp_imag;
    end else if (cmd_i.wr_lo) begin
      wr_en      = 1'b1;
      wr_data.re = scale_round(p_sre_q);
      wr_data.im = scale_round(p_sim_q);
    end else if (cmd_i.wr_hi) begin
      wr_en      = 1'b1;
      wr_data.re = scale_round(p_dre_q);
      wr_data.im = scale_round(p_dim_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= mem_q[cmd_i.addr_a[AW-1:0]];
      rd_b_q <= mem_q[cmd_i.addr_b[AW-1:0]];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_a_vld_q <= valid_q[cmd_i.addr_a[AW-1:0]];
        rd_b_vld_q <= valid_q[cmd_i.addr_b[AW-1:0]];
      end
    end
  end

  assign a = rd_a_vld_q ? rd_a_q : '0;
  assign b = rd_b_vld_q ? rd_b_q : '0;

  assign s_re = (AmpW+1)'(a.re) + (AmpW+1)'(b.re);
  assign s_im = (AmpW+1)'(a.im) + (AmpW+1)'(b.im);
  assign d_re = (AmpW+1)'(a.re) - (AmpW+1)'(b.re);
  assign d_im = (AmpW+1)'(a.im) - (AmpW+1)'(b.im);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_sre_q <= ProdW'(s_re) * ProdW'(InvSqrt2);
      p_sim_q <= ProdW'(s_im) * ProdW'(InvSqrt2);
      p_dre_q <= ProdW'(d_re) * ProdW'(InvSqrt2);
      p_dim_q <= ProdW'(d_im) * ProdW'(InvSqrt2);
    end
    if (cmd_i.out_load) begin
      out_q.out_index <= cmd_i.addr_a;
      out_q.out_real  <= a.re;
      out_q.out_imag  <= a.im;
      out_q.out_last  <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;
  assign sts_o.out_taken = out_valid_q && out_ready_i;

endmodule

[rtl/core/walsh_hadamard_transform.sv]
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o   in_item_i  (wht_pkg::in_item_t)
// out       output     out_valid_o/out_ready_i out_item_o (wht_pkg::out_item_t)
// cfg       input      cfg_we_i (no wait)      cfg_wdata_i (qubit_count)
//
// Flow: one item loads per cycle while in_ready_o is high. After the end-of-group
//   item, each butterfly uses the single store write port (read pair, multiply,
//   write lo, write hi), over q*2^(q-1) butterflies; then each of the 2^q results
//   is read, loaded and held in the output register until out_ready_i takes it.
// Reset: control and valid bits clear at once; no clearing pass over the store.
// Stalls: out_ready_i low holds the emit sequence; in_ready_o is low from the
//   end-of-group item until the last result of the group is taken.
module walsh_hadamard_transform #(
  parameter int unsigned MAX_QUBITS = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  wht_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output wht_pkg::out_item_t          out_item_o,
  input  logic                        cfg_we_i,
  input  logic [wht_pkg::QcntW-1:0]   cfg_wdata_i
);
  import wht_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // sequencer: load / butterfly stages / emit, holds qubit_count
  wht_ctrl #(
    .AW(MAX_QUBITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .group_end_i (in_item_i.group_end),
    .in_ready_o  (in_ready_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // amplitude store, butterfly arithmetic and output register
  wht_datapath #(
    .AW(MAX_QUBITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // a taken result that is not the last keeps the input closed
  a_mid_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_item_o.out_last) |=> !in_ready_o)
    else $error("input reopened before end of group");

  // the last result reopens the input
  a_group_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_item_o.out_last) |=> in_ready_o)
    else $error("input not reopened after last result");

  // each butterfly writes its low entry and then its high entry
  a_bf_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_lo |=> cmd.wr_hi)
    else $error("butterfly write pair broken");

endmodule
